FILE: design/ycrc_pkg.sv
// ----------------------------------------------------------------------------
// ycrc_pkg
// Shared types, register map and arithmetic constants for the YUYV crop and
// RGB conversion block.
// ----------------------------------------------------------------------------
package ycrc_pkg;

   // Compare width for window bounds, wide enough for every end sum
   localparam int CMP_W  = 16;
   localparam int PROD_W = 18;
   localparam int SUM_W  = 20;

   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH = 3'd0,
      CSR_CROP_LEFT   = 3'd1,
      CSR_CROP_TOP    = 3'd2,
      CSR_CROP_WIDTH  = 3'd3,
      CSR_CROP_HEIGHT = 3'd4
   } csr_index_type;

   localparam logic [12:0] RST_FRAME_WIDTH = 13'd1920;
   localparam logic [11:0] RST_CROP_LEFT   = 12'd800;
   localparam logic [11:0] RST_CROP_TOP    = 12'd380;
   localparam logic [12:0] RST_CROP_WIDTH  = 13'd320;
   localparam logic [12:0] RST_CROP_HEIGHT = 13'd240;

   typedef struct packed {
      logic [12:0] frame_width;
      logic [11:0] crop_left;
      logic [11:0] crop_top;
      logic [12:0] crop_width;
      logic [12:0] crop_height;
   } cfg_type;

   typedef struct packed {
      logic       last;
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
   } word_type;

   // BT.601 integer coefficients
   localparam logic signed [PROD_W-1:0] K_LUMA = 18'sd298;
   localparam logic signed [PROD_W-1:0] K_RV   = 18'sd409;
   localparam logic signed [PROD_W-1:0] K_GU   = 18'sd100;
   localparam logic signed [PROD_W-1:0] K_GV   = 18'sd208;
   localparam logic signed [PROD_W-1:0] K_BU   = 18'sd516;

   localparam logic signed [8:0]       LUMA_OFFSET = 9'sd16;
   localparam logic signed [SUM_W-1:0] ROUND       = 20'sd128;
   localparam logic signed [SUM_W-1:0] CHAN_MAX    = 20'sd255;

   // Arithmetic shift by 8, then clamp to 0..255
   function automatic logic [7:0] sat_channel(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] q;
      logic [7:0]              res;
      q = sum >>> 8;
      if (q > CHAN_MAX) begin
         res = 8'hFF;
      end else if (q < 0) begin
         res = 8'h00;
      end else begin
         res = q[7:0];
      end
      return res;
   endfunction

endpackage

FILE: design/ycrc_front.sv
// ----------------------------------------------------------------------------
// ycrc_front
// Takes requests, tracks pair column and line, and pushes words that fall in
// the crop window into the queue together with the last-of-window mark.
// ----------------------------------------------------------------------------
module ycrc_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                queue_full,
   input  logic                req_frame_start,
   input  logic [7:0]          req_luma_first,
   input  logic [7:0]          req_chroma_blue,
   input  logic [7:0]          req_luma_second,
   input  logic [7:0]          req_chroma_red,
   input  ycrc_pkg::cfg_type   cfg,
   output logic                push,
   output ycrc_pkg::word_type  push_data
);

   localparam int MAX_PAIRS = MAX_WIDTH / 2;
   localparam int COL_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW        = ycrc_pkg::CMP_W;

   logic [COL_W-1:0] col_ff, col_in, col;
   logic [ROW_W-1:0] row_ff, row_in, row;
   logic             accept;
   logic             in_window;
   logic             last;
   logic [CW-1:0]    pairs_raw, pairs;
   logic [CW-1:0]    left, width_pairs, col_end, row_top, row_end;
   logic [CW-1:0]    col_x, row_x, col_inc;

   assign accept = req_valid && !queue_full;

   always_comb begin
      col = req_frame_start ? '0 : col_ff;
      row = req_frame_start ? '0 : row_ff;

      pairs_raw = CW'(cfg.frame_width[12:1]);
      if (pairs_raw == '0) begin
         pairs = CW'(1);
      end else if (pairs_raw > CW'(MAX_PAIRS)) begin
         pairs = CW'(MAX_PAIRS);
      end else begin
         pairs = pairs_raw;
      end

      left        = CW'(cfg.crop_left[11:1]);
      width_pairs = CW'(cfg.crop_width[12:1]);
      col_end     = left + width_pairs;
      row_top     = CW'(cfg.crop_top);
      row_end     = row_top + CW'(cfg.crop_height);
      col_x       = CW'(col);
      row_x       = CW'(row);

      in_window = (width_pairs != '0) && (cfg.crop_height != '0) &&
                  (col_x >= left) && (col_x < col_end) &&
                  (row_x >= row_top) && (row_x < row_end);
      last      = (col_x == col_end - CW'(1)) && (row_x == row_end - CW'(1));

      col_inc = col_x + CW'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_inc >= pairs) begin
            col_in = '0;
            row_in = (row == ROW_W'(MAX_HEIGHT - 1)) ? '0 : row + ROW_W'(1);
         end else begin
            col_in = col_inc[COL_W-1:0];
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign push                  = accept && in_window;
   assign push_data.last        = last;
   assign push_data.luma_first  = req_luma_first;
   assign push_data.chroma_blue = req_chroma_blue;
   assign push_data.luma_second = req_luma_second;
   assign push_data.chroma_red  = req_chroma_red;

endmodule

FILE: design/ycrc_fifo.sv
// ----------------------------------------------------------------------------
// ycrc_fifo
// Short queue of window words between the classifier and the colour pipeline.
// ----------------------------------------------------------------------------
module ycrc_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ycrc_pkg::word_type  push_data,
   input  logic                pop,
   output ycrc_pkg::word_type  pop_data,
   output logic                full,
   output logic                empty
);

   localparam int PW = ycrc_pkg::FIFO_PTR_W;
   localparam int NW = ycrc_pkg::FIFO_CNT_W;

   ycrc_pkg::word_type mem_ff [ycrc_pkg::FIFO_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]      count_ff, count_in;

   assign full     = (count_ff == NW'(ycrc_pkg::FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/ycrc_back.sv
// ----------------------------------------------------------------------------
// ycrc_back
// Two-stage colour pipeline: coefficient products, then sums, rounding and
// saturation into the response register.
// ----------------------------------------------------------------------------
module ycrc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  ycrc_pkg::word_type  queue_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_red_first,
   output logic [7:0]          rsp_green_first,
   output logic [7:0]          rsp_blue_first,
   output logic [7:0]          rsp_red_second,
   output logic [7:0]          rsp_green_second,
   output logic [7:0]          rsp_blue_second,
   output logic                rsp_window_last
);

   localparam int PW = ycrc_pkg::PROD_W;
   localparam int SW = ycrc_pkg::SUM_W;

   logic                 a_valid_ff, a_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 a_ready, b_ready;

   logic signed [8:0]    y0c, y1c;
   logic signed [7:0]    d, e;

   // product stage
   logic signed [PW-1:0] luma0_ff, luma0_in;
   logic signed [PW-1:0] luma1_ff, luma1_in;
   logic signed [PW-1:0] rv_ff, rv_in;
   logic signed [PW-1:0] gu_ff, gu_in;
   logic signed [PW-1:0] gv_ff, gv_in;
   logic signed [PW-1:0] bu_ff, bu_in;
   logic                 a_last_ff, a_last_in;

   // response stage
   logic signed [SW-1:0] r0, g0, b0, r1, g1, b1;
   logic [7:0]           red0_ff, green0_ff, blue0_ff;
   logic [7:0]           red1_ff, green1_ff, blue1_ff;
   logic                 last_ff;

   assign b_ready = !rsp_valid_ff || !rsp_stall;
   assign a_ready = !a_valid_ff || b_ready;
   assign pop     = !queue_empty && a_ready;

   always_comb begin
      // U-128 and V-128 by flipping the top bit
      d   = $signed({~queue_data.chroma_blue[7], queue_data.chroma_blue[6:0]});
      e   = $signed({~queue_data.chroma_red[7], queue_data.chroma_red[6:0]});
      y0c = $signed({1'b0, queue_data.luma_first})  - ycrc_pkg::LUMA_OFFSET;
      y1c = $signed({1'b0, queue_data.luma_second}) - ycrc_pkg::LUMA_OFFSET;

      luma0_in  = PW'(y0c) * ycrc_pkg::K_LUMA;
      luma1_in  = PW'(y1c) * ycrc_pkg::K_LUMA;
      rv_in     = PW'(e) * ycrc_pkg::K_RV;
      gu_in     = PW'(d) * ycrc_pkg::K_GU;
      gv_in     = PW'(e) * ycrc_pkg::K_GV;
      bu_in     = PW'(d) * ycrc_pkg::K_BU;
      a_last_in = queue_data.last;

      r0 = SW'(luma0_ff) + SW'(rv_ff) + ycrc_pkg::ROUND;
      g0 = SW'(luma0_ff) - SW'(gu_ff) - SW'(gv_ff) + ycrc_pkg::ROUND;
      b0 = SW'(luma0_ff) + SW'(bu_ff) + ycrc_pkg::ROUND;
      r1 = SW'(luma1_ff) + SW'(rv_ff) + ycrc_pkg::ROUND;
      g1 = SW'(luma1_ff) - SW'(gu_ff) - SW'(gv_ff) + ycrc_pkg::ROUND;
      b1 = SW'(luma1_ff) + SW'(bu_ff) + ycrc_pkg::ROUND;

      a_valid_in   = a_ready ? !queue_empty : a_valid_ff;
      rsp_valid_in = b_ready ? a_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         luma0_ff  <= luma0_in;
         luma1_ff  <= luma1_in;
         rv_ff     <= rv_in;
         gu_ff     <= gu_in;
         gv_ff     <= gv_in;
         bu_ff     <= bu_in;
         a_last_ff <= a_last_in;
      end
      if (b_ready && a_valid_ff) begin
         red0_ff   <= ycrc_pkg::sat_channel(r0);
         green0_ff <= ycrc_pkg::sat_channel(g0);
         blue0_ff  <= ycrc_pkg::sat_channel(b0);
         red1_ff   <= ycrc_pkg::sat_channel(r1);
         green1_ff <= ycrc_pkg::sat_channel(g1);
         blue1_ff  <= ycrc_pkg::sat_channel(b1);
         last_ff   <= a_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_first    = red0_ff;
   assign rsp_green_first  = green0_ff;
   assign rsp_blue_first   = blue0_ff;
   assign rsp_red_second   = red1_ff;
   assign rsp_green_second = green1_ff;
   assign rsp_blue_second  = blue1_ff;
   assign rsp_window_last  = last_ff;

endmodule

FILE: design/yuyv_crop_and_rgb_convert.sv
// ----------------------------------------------------------------------------
// yuyv_crop_and_rgb_convert
// Crops a YUYV raster to a window and converts each pixel pair to BT.601 RGB.
// ----------------------------------------------------------------------------
// A window request passes through the queue, the product registers and the response register before it appears on rsp.
// Throughput: one request per cycle while rsp_stall is low, set by the two-stage colour
// pipeline behind a four-entry queue; req_stall rises only when that queue is full.
// Reset clears the column and line counters, the queue and pipeline valids,
// and restores the crop registers to their default values.
module yuyv_crop_and_rgb_convert #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_frame_start,
   input  logic [7:0]                        req_luma_first,
   input  logic [7:0]                        req_chroma_blue,
   input  logic [7:0]                        req_luma_second,
   input  logic [7:0]                        req_chroma_red,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_red_first,
   output logic [7:0]                        rsp_green_first,
   output logic [7:0]                        rsp_blue_first,
   output logic [7:0]                        rsp_red_second,
   output logic [7:0]                        rsp_green_second,
   output logic [7:0]                        rsp_blue_second,
   output logic                              rsp_window_last,
   input  logic                              csr_write_enable,
   input  logic [ycrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ycrc_pkg::CSR_W-1:0]        csr_write_data
);

   ycrc_pkg::cfg_type  cfg_ff, cfg_in;
   ycrc_pkg::word_type push_data, pop_data;
   logic               push, pop, full, empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ycrc_pkg::CSR_FRAME_WIDTH: cfg_in.frame_width = csr_write_data;
            ycrc_pkg::CSR_CROP_LEFT:   cfg_in.crop_left   = csr_write_data[11:0];
            ycrc_pkg::CSR_CROP_TOP:    cfg_in.crop_top    = csr_write_data[11:0];
            ycrc_pkg::CSR_CROP_WIDTH:  cfg_in.crop_width  = csr_write_data;
            ycrc_pkg::CSR_CROP_HEIGHT: cfg_in.crop_height = csr_write_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width <= ycrc_pkg::RST_FRAME_WIDTH;
         cfg_ff.crop_left   <= ycrc_pkg::RST_CROP_LEFT;
         cfg_ff.crop_top    <= ycrc_pkg::RST_CROP_TOP;
         cfg_ff.crop_width  <= ycrc_pkg::RST_CROP_WIDTH;
         cfg_ff.crop_height <= ycrc_pkg::RST_CROP_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = full;

   ycrc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .queue_full      (full),
      .req_frame_start (req_frame_start),
      .req_luma_first  (req_luma_first),
      .req_chroma_blue (req_chroma_blue),
      .req_luma_second (req_luma_second),
      .req_chroma_red  (req_chroma_red),
      .cfg             (cfg_ff),
      .push            (push),
      .push_data       (push_data)
   );

   ycrc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   ycrc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (empty),
      .queue_data       (pop_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_first    (rsp_red_first),
      .rsp_green_first  (rsp_green_first),
      .rsp_blue_first   (rsp_blue_first),
      .rsp_red_second   (rsp_red_second),
      .rsp_green_second (rsp_green_second),
      .rsp_blue_second  (rsp_blue_second),
      .rsp_window_last  (rsp_window_last)
   );

   // the classifier must never write into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");

   // a pushed request is held in the queue on the next cycle
   assert property (@(posedge clock) disable iff (reset) push |=> !empty)
      else $error("pushed request lost");

   // queue comes out of reset empty, so requests are taken at once
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !req_stall)
      else $error("stall raised straight after reset");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YUYV crop and RGB conversion block. Requests
// are driven with random gaps and the output is stalled at random. Each
// accepted request is run through a local window and colour predictor, and
// every result is compared field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_WIDTH    = 4096;
   localparam int MAX_HEIGHT   = 4096;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int RANDOM_WORDS = 560;
   localparam int DEFAULT_ROWS = 3;
   localparam int DIRECTED_ROWS = 17;

   typedef struct {
      bit         frame_start;
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
   } yuyv_word_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct {
      rgb_type first;
      rgb_type second;
      logic    window_last;
   } pixel_pair_type;

   // grey: every channel of both pixels, used on typed rows only
   typedef struct {
      bit         frame_start;
      logic [7:0] y1;
      logic [7:0] u;
      logic [7:0] y2;
      logic [7:0] v;
      bit         typed;
      bit         want_hit;
      logic [7:0] grey;
      bit         want_last;
   } directed_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_frame_start = 1'b0;
   logic [7:0]                    req_luma_first = 8'd0;
   logic [7:0]                    req_chroma_blue = 8'd0;
   logic [7:0]                    req_luma_second = 8'd0;
   logic [7:0]                    req_chroma_red = 8'd0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [7:0]                    rsp_red_first;
   logic [7:0]                    rsp_green_first;
   logic [7:0]                    rsp_blue_first;
   logic [7:0]                    rsp_red_second;
   logic [7:0]                    rsp_green_second;
   logic [7:0]                    rsp_blue_second;
   logic                          rsp_window_last;
   logic                          csr_write_enable = 1'b0;
   ycrc_pkg::csr_index_type       csr_index = ycrc_pkg::CSR_FRAME_WIDTH;
   logic [ycrc_pkg::CSR_W-1:0]    csr_write_data = '0;

   // predictor copy of the registers and counters
   logic [12:0] cfg_frame_width = ycrc_pkg::RST_FRAME_WIDTH;
   logic [11:0] cfg_crop_left   = ycrc_pkg::RST_CROP_LEFT;
   logic [11:0] cfg_crop_top    = ycrc_pkg::RST_CROP_TOP;
   logic [12:0] cfg_crop_width  = ycrc_pkg::RST_CROP_WIDTH;
   logic [12:0] cfg_crop_height = ycrc_pkg::RST_CROP_HEIGHT;
   int          pair_col = 0;
   int          line_row = 0;

   pixel_pair_type pending_pixels[$];
   pixel_pair_type oldest_pair;
   pixel_pair_type no_pair;

   int error_count = 0;
   int words_accepted = 0;
   int window_hits = 0;
   int lasts_predicted = 0;
   int input_stall_cycles = 0;
   int window_settings = 0;
   int frames_sent = 0;
   int cycle_count = 0;
   int req_idle_pct = 9;
   int rsp_idle_pct = 9;
   int hold_requests = 0;
   int holds_served = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // default window after reset: line 0 is far above it
      '{1'b1, 8'h10, 8'h80, 8'hEB, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      // 4 pairs per line, window pairs 1..2 on lines 1..2
      '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'h3C, 8'h5A, 8'hC3, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'h81, 8'h7F, 8'h01, 8'hFE, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'hFF, 8'h80, 8'hFF, 8'h80, 1'b1, 1'b1, 8'hFF, 1'b0},
      '{1'b0, 8'h00, 8'h80, 8'h10, 8'h80, 1'b1, 1'b1, 8'h00, 1'b0},
      '{1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'h7E, 8'h01, 8'hE7, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 8'hEB, 8'h80, 8'hEB, 8'h80, 1'b1, 1'b1, 8'hFF, 1'b1},
      '{1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
      // restart twice in a row
      '{1'b1, 8'h80, 8'hFF, 8'h80, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b1, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 1'b0, 8'h00, 1'b0}
   };

   yuyv_crop_and_rgb_convert dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_start  (req_frame_start),
      .req_luma_first   (req_luma_first),
      .req_chroma_blue  (req_chroma_blue),
      .req_luma_second  (req_luma_second),
      .req_chroma_red   (req_chroma_red),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_first    (rsp_red_first),
      .rsp_green_first  (rsp_green_first),
      .rsp_blue_first   (rsp_blue_first),
      .rsp_red_second   (rsp_red_second),
      .rsp_green_second (rsp_green_second),
      .rsp_blue_second  (rsp_blue_second),
      .rsp_window_last  (rsp_window_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         flag_error($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   // arithmetic shift, then clamp to 0..255
   function automatic logic [7:0] clamp_channel(input int sum);
      int q;
      q = sum >>> 8;
      if (q > 255) return 8'd255;
      if (q < 0) return 8'd0;
      return q[7:0];
   endfunction

   function automatic rgb_type yuv_to_rgb(input int luma, input int d, input int e);
      rgb_type px;
      int      c;
      c = 298 * (luma - 16);
      px.red   = clamp_channel(c + 409 * e + 128);
      px.green = clamp_channel(c - 100 * d - 208 * e + 128);
      px.blue  = clamp_channel(c + 516 * d + 128);
      return px;
   endfunction

   // window test at full precision, then advance the pair and line counters
   task automatic convert_word(input yuyv_word_type w, output bit hit,
                               output pixel_pair_type px);
      int pairs;
      int left_pair;
      int width_pairs;
      int col;
      int row;
      int d;
      int e;
      pairs = int'(cfg_frame_width) >> 1;
      if (pairs < 1) pairs = 1;
      if (pairs > MAX_WIDTH / 2) pairs = MAX_WIDTH / 2;
      left_pair   = int'(cfg_crop_left) >> 1;
      width_pairs = int'(cfg_crop_width) >> 1;
      if (w.frame_start) begin
         pair_col = 0;
         line_row = 0;
      end
      col = pair_col;
      row = line_row;
      hit = width_pairs != 0 && cfg_crop_height != 0 &&
            col >= left_pair && col < left_pair + width_pairs &&
            row >= int'(cfg_crop_top) && row < int'(cfg_crop_top) + int'(cfg_crop_height);
      px = no_pair;
      if (hit) begin
         d = int'(w.chroma_blue) - 128;
         e = int'(w.chroma_red) - 128;
         px.first  = yuv_to_rgb(int'(w.luma_first), d, e);
         px.second = yuv_to_rgb(int'(w.luma_second), d, e);
         px.window_last = (col == left_pair + width_pairs - 1) &&
                          (row == int'(cfg_crop_top) + int'(cfg_crop_height) - 1);
      end
      col++;
      if (col >= pairs) begin
         col = 0;
         row++;
         if (row >= MAX_HEIGHT) row = 0;
      end
      pair_col = col;
      line_row = row;
   endtask

   task automatic send_request(input yuyv_word_type w, input bit typed, input bit typed_hit,
                               input pixel_pair_type typed_px);
      bit             hit;
      pixel_pair_type px;
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_frame_start <= w.frame_start;
      req_luma_first  <= w.luma_first;
      req_chroma_blue <= w.chroma_blue;
      req_luma_second <= w.luma_second;
      req_chroma_red  <= w.chroma_red;
      do @(posedge clock); while (req_stall);
      words_accepted++;
      convert_word(w, hit, px);
      if (typed) begin
         hit = typed_hit;
         px  = typed_px;
      end
      if (hit) begin
         window_hits++;
         if (px.window_last) lasts_predicted++;
         pending_pixels.push_back(px);
      end
   endtask

   // extremes come up often so saturation is hit on both ends
   function automatic logic [7:0] pick_sample();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic yuyv_word_type random_word(input bit fs);
      yuyv_word_type w;
      w.frame_start = fs;
      w.luma_first  = pick_sample();
      w.chroma_blue = pick_sample();
      w.luma_second = pick_sample();
      w.chroma_red  = pick_sample();
      return w;
   endfunction

   // no register write until every request is through the pipe
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input ycrc_pkg::csr_index_type idx,
                            input logic [ycrc_pkg::CSR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         ycrc_pkg::CSR_FRAME_WIDTH: cfg_frame_width = value;
         ycrc_pkg::CSR_CROP_LEFT:   cfg_crop_left   = value[11:0];
         ycrc_pkg::CSR_CROP_TOP:    cfg_crop_top    = value[11:0];
         ycrc_pkg::CSR_CROP_WIDTH:  cfg_crop_width  = value;
         ycrc_pkg::CSR_CROP_HEIGHT: cfg_crop_height = value;
         default: ;
      endcase
   endtask

   task automatic program_window(input logic [ycrc_pkg::CSR_W-1:0] fw,
                                 input logic [ycrc_pkg::CSR_W-1:0] left,
                                 input logic [ycrc_pkg::CSR_W-1:0] top,
                                 input logic [ycrc_pkg::CSR_W-1:0] cw,
                                 input logic [ycrc_pkg::CSR_W-1:0] ch);
      write_csr(ycrc_pkg::CSR_FRAME_WIDTH, fw);
      write_csr(ycrc_pkg::CSR_CROP_LEFT, left);
      write_csr(ycrc_pkg::CSR_CROP_TOP, top);
      write_csr(ycrc_pkg::CSR_CROP_WIDTH, cw);
      write_csr(ycrc_pkg::CSR_CROP_HEIGHT, ch);
      csr_write_enable <= 1'b0;
      window_settings++;
   endtask

   task automatic run_words(input int count, input bit restart);
      for (int k = 0; k < count; k++) begin
         send_request(random_word(restart && k == 0), 1'b0, 1'b0, no_pair);
      end
   endtask

   // mostly whole frames over a small raster; some wild settings, truncated
   // frames, missing frame starts and stray restarts mixed in
   task automatic random_frame();
      int  fw;
      int  pairs;
      int  words;
      bit  first_fs;
      settle();
      if ($urandom_range(9) == 0) begin
         program_window(13'($urandom_range(8191)), 13'($urandom_range(8191)),
                        13'($urandom_range(8191)), 13'($urandom_range(8191)),
                        13'($urandom_range(8191)));
         words = $urandom_range(8, 48);
      end else begin
         fw    = $urandom_range(2, 24);
         pairs = (fw >> 1) < 1 ? 1 : fw >> 1;
         program_window(13'(fw), 13'($urandom_range(fw + 1) | ($urandom_range(1) << 12)),
                        13'($urandom_range(3) | ($urandom_range(1) << 12)),
                        13'($urandom_range(fw + 2)), 13'($urandom_range(4)));
         words = pairs * (int'(cfg_crop_top) + int'(cfg_crop_height) + $urandom_range(1));
         if (words < 1) words = pairs;
         if (words > pairs * 8) words = pairs * 8;
         if ($urandom_range(7) == 0) words = $urandom_range(1, words);
      end
      first_fs = $urandom_range(14) != 0;
      for (int k = 0; k < words; k++) begin
         send_request(random_word(k == 0 ? first_fs : $urandom_range(79) == 0),
                      1'b0, 1'b0, no_pair);
      end
      frames_sent++;
   endtask

   // output side: random stalls, plus one long hold when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               flag_error("result with nothing expected");
            end else begin
               oldest_pair = pending_pixels.pop_front();
               check_field("red_first", rsp_red_first, oldest_pair.first.red);
               check_field("green_first", rsp_green_first, oldest_pair.first.green);
               check_field("blue_first", rsp_blue_first, oldest_pair.first.blue);
               check_field("red_second", rsp_red_second, oldest_pair.second.red);
               check_field("green_second", rsp_green_second, oldest_pair.second.green);
               check_field("blue_second", rsp_blue_second, oldest_pair.second.blue);
               check_field("window_last", 8'(rsp_window_last), 8'(oldest_pair.window_last));
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out with %0d results outstanding", pending_pixels.size());
      $display("Verification failed");
      $finish;
   end

   initial begin
      yuyv_word_type  w;
      pixel_pair_type typed_px;
      int             words_base;
      int             got;

      no_pair = '{'{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0}, 1'b0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (i == DEFAULT_ROWS) begin
            settle();
            program_window(13'd8, 13'd2, 13'd1, 13'd4, 13'd2);
         end
         w.frame_start = directed_rows[i].frame_start;
         w.luma_first  = directed_rows[i].y1;
         w.chroma_blue = directed_rows[i].u;
         w.luma_second = directed_rows[i].y2;
         w.chroma_red  = directed_rows[i].v;
         typed_px.first  = '{directed_rows[i].grey, directed_rows[i].grey,
                             directed_rows[i].grey};
         typed_px.second = typed_px.first;
         typed_px.window_last = directed_rows[i].want_last;
         send_request(w, directed_rows[i].typed, directed_rows[i].want_hit, typed_px);
      end

      // frame width of 1: one pair per line
      settle();
      program_window(13'd1, 13'd1, 13'd2, 13'd3, 13'd3);
      run_words(8, 1'b1);

      // empty windows: width below one pair, then zero height
      settle();
      program_window(13'd8, 13'd0, 13'd0, 13'd1, 13'd5);
      run_words(12, 1'b1);
      settle();
      program_window(13'd8, 13'd0, 13'd0, 13'd8, 13'd0);
      run_words(12, 1'b1);

      // zero width frame: one pair per line, window on a single line
      settle();
      program_window(13'd0, 13'd0, 13'd2, 13'd2, 13'd1);
      run_words(6, 1'b1);

      // oversize frame width; window runs past the right edge
      settle();
      program_window(13'd8191, 13'd0, 13'd0, 13'd8191, 13'd8191);
      run_words(40, 1'b1);

      // output held off while requests keep coming, so the input stalls
      settle();
      program_window(13'd16, 13'd0, 13'd0, 13'd16, 13'd8191);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_requests++;
      run_words(60, 1'b1);
      req_idle_pct = 9;
      rsp_idle_pct = 9;

      words_base = words_accepted;
      got = 0;
      while (got < RANDOM_WORDS) begin
         // a stretch with no idling on either side
         if (got >= 250 && got < 400) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 9;
            rsp_idle_pct = 9;
         end
         random_frame();
         got = words_accepted - words_base;
      end

      settle();
      $display("Ran %0d requests in %0d window settings and %0d random frames",
               words_accepted, window_settings, frames_sent);
      $display("%0d pixel pairs converted, %0d window ends, input stalled %0d cycles",
               window_hits, lasts_predicted, input_stall_cycles);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
